@@ design/aafe_pkg.sv @@
// Shared types, constants and character helpers for the ASCII attitude frame encoder.
`timescale 1ns / 1ps

package aafe_pkg;

    // Input word layout, lowest bit first
    localparam int IN_TDATA_W = 112;
    localparam int OFS_PITCH  = 0;
    localparam int OFS_ROLL   = 16;
    localparam int OFS_IAS    = 32;
    localparam int OFS_ALT    = 48;
    localparam int OFS_LAT    = 66;
    localparam int OFS_VERT   = 82;
    localparam int OFS_LIFT   = 98;

    // Field limits
    localparam logic signed [15:0] PITCH_LIM = 16'sd999;
    localparam logic signed [15:0] ROLL_LIM  = 16'sd9999;
    localparam logic signed [15:0] IAS_LIM   = 16'sd9999;
    localparam logic signed [17:0] ALT_LIM   = 18'sd99999;
    localparam logic signed [15:0] G_LIM     = 16'sd99;
    localparam logic [6:0]         LIFT_LIM  = 7'd99;

    // Binary to BCD converter lanes
    localparam int NLANE      = 7;
    localparam int LANE_PITCH = 0;
    localparam int LANE_ROLL  = 1;
    localparam int LANE_IAS   = 2;
    localparam int LANE_ALT   = 3;
    localparam int LANE_LAT   = 4;
    localparam int LANE_VERT  = 5;
    localparam int LANE_LIFT  = 6;
    localparam int MAG_W      = 17;
    localparam int BCD_W      = 20;
    localparam int ITERS      = MAG_W;
    localparam int ITER_W     = $clog2(ITERS);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ITERS - 1);

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Frame character positions
    localparam logic [5:0] POS_SOF    = 6'd0;
    localparam logic [5:0] POS_ONE_A  = 6'd1;
    localparam logic [5:0] POS_ONE_B  = 6'd2;
    localparam logic [5:0] POS_ZERO_A = 6'd3;
    localparam logic [5:0] POS_ZERO_B = 6'd10;
    localparam logic [5:0] POS_PITCH  = 6'd11;
    localparam logic [5:0] POS_ROLL   = 6'd15;
    localparam logic [5:0] POS_FILL_A = 6'd20;
    localparam logic [5:0] POS_IAS    = 6'd23;
    localparam logic [5:0] POS_ALT    = 6'd27;
    localparam logic [5:0] POS_FILL_B = 6'd33;
    localparam logic [5:0] POS_LAT    = 6'd37;
    localparam logic [5:0] POS_VERT   = 6'd40;
    localparam logic [5:0] POS_LIFT   = 6'd43;
    localparam logic [5:0] POS_FILL_C = 6'd45;
    localparam logic [5:0] POS_SUM_HI = 6'd55;
    localparam logic [5:0] POS_SUM_LO = 6'd56;
    localparam logic [5:0] POS_CR     = 6'd57;
    localparam logic [5:0] POS_LF     = 6'd58;

    // ASCII codes
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_FILL  = 8'h5F;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] HEX_ALPHA_BASE = 8'h37;

    // Converter state
    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_RUN,
        CONV_DONE
    } conv_state_t;

    // One decoded frame: signs and BCD digits
    typedef struct packed {
        logic        pitch_neg;
        logic        roll_neg;
        logic        alt_neg;
        logic        lat_neg;
        logic        vert_neg;
        logic [11:0] pitch_bcd;
        logic [15:0] roll_bcd;
        logic [15:0] ias_bcd;
        logic [19:0] alt_bcd;
        logic [7:0]  lat_bcd;
        logic [7:0]  vert_bcd;
        logic [7:0]  lift_bcd;
    } job_t;

    // One shift-add-3 step
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                                 input logic bit_in);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int i = 0; i < BCD_W / 4; i++) begin
            if (adj[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

    function automatic logic [7:0] dig(input logic [3:0] d);
        return {4'h3, d};
    endfunction

    function automatic logic [7:0] sgn(input logic neg);
        return neg ? CH_MINUS : CH_PLUS;
    endfunction

    function automatic logic [7:0] hex(input logic [3:0] n);
        return (n < 4'd10) ? {4'h3, n} : HEX_ALPHA_BASE + {4'h0, n};
    endfunction

    // Character at a frame position
    function automatic logic [7:0] char_at(input logic [5:0] pos, input job_t j,
                                           input logic [7:0] sum);
        logic [7:0] c;
        case (pos) inside
            POS_SOF:                            c = CH_EQ;
            [POS_ONE_A:POS_ONE_B]:              c = CH_ONE;
            [POS_ZERO_A:POS_ZERO_B]:            c = CH_ZERO;
            POS_PITCH:                          c = sgn(j.pitch_neg);
            POS_PITCH + 6'd1:                   c = dig(j.pitch_bcd[11:8]);
            POS_PITCH + 6'd2:                   c = dig(j.pitch_bcd[7:4]);
            POS_PITCH + 6'd3:                   c = dig(j.pitch_bcd[3:0]);
            POS_ROLL:                           c = sgn(j.roll_neg);
            POS_ROLL + 6'd1:                    c = dig(j.roll_bcd[15:12]);
            POS_ROLL + 6'd2:                    c = dig(j.roll_bcd[11:8]);
            POS_ROLL + 6'd3:                    c = dig(j.roll_bcd[7:4]);
            POS_ROLL + 6'd4:                    c = dig(j.roll_bcd[3:0]);
            [POS_FILL_A:POS_FILL_A + 6'd2]:     c = CH_FILL;
            POS_IAS:                            c = dig(j.ias_bcd[15:12]);
            POS_IAS + 6'd1:                     c = dig(j.ias_bcd[11:8]);
            POS_IAS + 6'd2:                     c = dig(j.ias_bcd[7:4]);
            POS_IAS + 6'd3:                     c = dig(j.ias_bcd[3:0]);
            POS_ALT:                            c = sgn(j.alt_neg);
            POS_ALT + 6'd1:                     c = dig(j.alt_bcd[19:16]);
            POS_ALT + 6'd2:                     c = dig(j.alt_bcd[15:12]);
            POS_ALT + 6'd3:                     c = dig(j.alt_bcd[11:8]);
            POS_ALT + 6'd4:                     c = dig(j.alt_bcd[7:4]);
            POS_ALT + 6'd5:                     c = dig(j.alt_bcd[3:0]);
            [POS_FILL_B:POS_FILL_B + 6'd3]:     c = CH_FILL;
            POS_LAT:                            c = sgn(j.lat_neg);
            POS_LAT + 6'd1:                     c = dig(j.lat_bcd[7:4]);
            POS_LAT + 6'd2:                     c = dig(j.lat_bcd[3:0]);
            POS_VERT:                           c = sgn(j.vert_neg);
            POS_VERT + 6'd1:                    c = dig(j.vert_bcd[7:4]);
            POS_VERT + 6'd2:                    c = dig(j.vert_bcd[3:0]);
            POS_LIFT:                           c = dig(j.lift_bcd[7:4]);
            POS_LIFT + 6'd1:                    c = dig(j.lift_bcd[3:0]);
            [POS_FILL_C:POS_FILL_C + 6'd9]:     c = CH_FILL;
            POS_SUM_HI:                         c = hex(sum[7:4]);
            POS_SUM_LO:                         c = hex(sum[3:0]);
            POS_CR:                             c = CH_CR;
            POS_LF:                             c = CH_LF;
            default:                            c = CH_NUL;
        endcase
        return c;
    endfunction

endpackage

@@ design/ascii_attitude_frame_encoder_top.sv @@
// Throughput: one character per cycle while m_tready does not stall, 59 characters per frame
// set by the back-end position counter; the BCD converter takes one sample word at a time and
// a two-entry queue keeps the back end fed so frames follow each other without gaps.
// Reset (rst_n, async low): queue empty, converter idle, mute threshold 0, no output word.
`timescale 1ns / 1ps

module ascii_attitude_frame_encoder_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [7:0]                      cfg_wdata,  // mute_airspeed_knots
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: pitch_tenths[15:0], roll_tenths[31:16], airspeed_tenths[47:32],
    // altitude_feet[65:48], lateral_hundredths[81:66], vertical_tenths[97:82],
    // lift_percent[104:98], zero fill[111:105]
    input  logic [aafe_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,    // out_byte[7:0]
    output logic                            m_tlast     // frame_end
);

    logic           fq_valid, fq_ready;
    aafe_pkg::job_t fq_data;
    logic           bq_valid, bq_pop;
    aafe_pkg::job_t bq_data;

    // Front: accept, clamp, convert
    aafe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_data    (fq_data)
    );

    // Decoded frame queue
    aafe_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (bq_valid),
        .rd_pop   (bq_pop),
        .rd_data  (bq_data)
    );

    // Back: character serializer
    aafe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (bq_valid),
        .job_pop   (bq_pop),
        .job       (bq_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

@@ design/aafe_front.sv @@
// Front end: accepts sample words, clamps and mutes, converts magnitudes to BCD.
`timescale 1ns / 1ps

module aafe_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [7:0]                        cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [aafe_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                              q_valid,
    input  logic                              q_ready,
    output aafe_pkg::job_t                    q_data
);

    logic [7:0] mute_reg;

    // Stage 1: clamped sample set
    logic               s1_valid_reg, s1_valid_next;
    logic signed [10:0] s1_pitch_reg;
    logic signed [14:0] s1_roll_reg;
    logic [13:0]        s1_ias_reg;
    logic signed [17:0] s1_alt_reg;
    logic signed [7:0]  s1_lat_reg;
    logic signed [7:0]  s1_vert_reg;
    logic [6:0]         s1_lift_reg;

    logic signed [15:0] pitch_in, roll_in, ias_in, lat_in, vert_in;
    logic signed [17:0] alt_in;
    logic [6:0]         lift_in;
    logic [11:0]        mute10;
    logic               live;
    logic signed [15:0] pitch_c, roll_c, lat_c, vert_c;
    logic signed [17:0] alt_c;
    logic [13:0]        ias_c;
    logic [6:0]         lift_c;
    logic               accept;

    // Converter
    aafe_pkg::conv_state_t      state_reg, state_next;
    logic [aafe_pkg::ITER_W-1:0] iter_reg, iter_next;
    logic [aafe_pkg::MAG_W-1:0] mag_reg [aafe_pkg::NLANE];
    logic [aafe_pkg::BCD_W-1:0] bcd_reg [aafe_pkg::NLANE];
    logic [aafe_pkg::MAG_W-1:0] mag_load [aafe_pkg::NLANE];
    logic [4:0]                 neg_reg;
    logic                       conv_load;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mute_reg <= 8'd0;
        end
        else if (cfg_we)
        begin
            mute_reg <= cfg_wdata;
        end
    end

    // Field extraction, clamping and muting
    always_comb
    begin
        pitch_in = $signed(s_tdata[aafe_pkg::OFS_PITCH +: 16]);
        roll_in  = $signed(s_tdata[aafe_pkg::OFS_ROLL +: 16]);
        ias_in   = $signed(s_tdata[aafe_pkg::OFS_IAS +: 16]);
        alt_in   = $signed(s_tdata[aafe_pkg::OFS_ALT +: 18]);
        lat_in   = $signed(s_tdata[aafe_pkg::OFS_LAT +: 16]);
        vert_in  = $signed(s_tdata[aafe_pkg::OFS_VERT +: 16]);
        lift_in  = s_tdata[aafe_pkg::OFS_LIFT +: 7];

        mute10 = {1'b0, mute_reg, 3'b000} + {3'b000, mute_reg, 1'b0};
        live   = $signed({ias_in[15], ias_in}) >= $signed({5'b00000, mute10});

        if (pitch_in < -aafe_pkg::PITCH_LIM)     pitch_c = -aafe_pkg::PITCH_LIM;
        else if (pitch_in > aafe_pkg::PITCH_LIM) pitch_c = aafe_pkg::PITCH_LIM;
        else                                     pitch_c = pitch_in;

        if (roll_in < -aafe_pkg::ROLL_LIM)       roll_c = -aafe_pkg::ROLL_LIM;
        else if (roll_in > aafe_pkg::ROLL_LIM)   roll_c = aafe_pkg::ROLL_LIM;
        else                                     roll_c = roll_in;

        if (alt_in < -aafe_pkg::ALT_LIM)         alt_c = -aafe_pkg::ALT_LIM;
        else if (alt_in > aafe_pkg::ALT_LIM)     alt_c = aafe_pkg::ALT_LIM;
        else                                     alt_c = alt_in;

        if (lat_in < -aafe_pkg::G_LIM)           lat_c = -aafe_pkg::G_LIM;
        else if (lat_in > aafe_pkg::G_LIM)       lat_c = aafe_pkg::G_LIM;
        else                                     lat_c = lat_in;

        if (vert_in < -aafe_pkg::G_LIM)          vert_c = -aafe_pkg::G_LIM;
        else if (vert_in > aafe_pkg::G_LIM)      vert_c = aafe_pkg::G_LIM;
        else                                     vert_c = vert_in;

        if (!live || ias_in < 16'sd0)            ias_c = 14'd0;
        else if (ias_in > aafe_pkg::IAS_LIM)     ias_c = aafe_pkg::IAS_LIM[13:0];
        else                                     ias_c = ias_in[13:0];

        if (!live)                               lift_c = 7'd0;
        else if (lift_in > aafe_pkg::LIFT_LIM)   lift_c = aafe_pkg::LIFT_LIM;
        else                                     lift_c = lift_in;
    end

    // Stage 1 handshake: refills as soon as the converter takes the word
    assign conv_load = s1_valid_reg && (state_reg == aafe_pkg::CONV_IDLE);
    assign s_tready  = !s1_valid_reg || conv_load;
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (conv_load)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pitch_reg <= pitch_c[10:0];
            s1_roll_reg  <= roll_c[14:0];
            s1_ias_reg   <= ias_c;
            s1_alt_reg   <= alt_c;
            s1_lat_reg   <= lat_c[7:0];
            s1_vert_reg  <= vert_c[7:0];
            s1_lift_reg  <= lift_c;
        end
    end

    // Magnitudes loaded into the converter lanes
    always_comb
    begin
        mag_load[aafe_pkg::LANE_PITCH] = s1_pitch_reg[10]
            ? 17'(-$signed({{6{s1_pitch_reg[10]}}, s1_pitch_reg}))
            : {6'd0, s1_pitch_reg};
        mag_load[aafe_pkg::LANE_ROLL] = s1_roll_reg[14]
            ? 17'(-$signed({{2{s1_roll_reg[14]}}, s1_roll_reg}))
            : {2'd0, s1_roll_reg};
        mag_load[aafe_pkg::LANE_IAS] = {3'd0, s1_ias_reg};
        mag_load[aafe_pkg::LANE_ALT] = s1_alt_reg[17]
            ? 17'(-s1_alt_reg)
            : s1_alt_reg[16:0];
        mag_load[aafe_pkg::LANE_LAT] = s1_lat_reg[7]
            ? 17'(-$signed({{9{s1_lat_reg[7]}}, s1_lat_reg}))
            : {9'd0, s1_lat_reg};
        mag_load[aafe_pkg::LANE_VERT] = s1_vert_reg[7]
            ? 17'(-$signed({{9{s1_vert_reg[7]}}, s1_vert_reg}))
            : {9'd0, s1_vert_reg};
        mag_load[aafe_pkg::LANE_LIFT] = {10'd0, s1_lift_reg};
    end

    // Converter sequencer
    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        case (state_reg)
            aafe_pkg::CONV_IDLE:
            begin
                if (conv_load)
                begin
                    state_next = aafe_pkg::CONV_RUN;
                    iter_next  = '0;
                end
            end
            aafe_pkg::CONV_RUN:
            begin
                iter_next = iter_reg + 1'b1;
                if (iter_reg == aafe_pkg::ITER_LAST)
                begin
                    state_next = aafe_pkg::CONV_DONE;
                end
            end
            aafe_pkg::CONV_DONE:
            begin
                if (q_ready)
                begin
                    state_next = aafe_pkg::CONV_IDLE;
                end
            end
            default:
            begin
                state_next = aafe_pkg::CONV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aafe_pkg::CONV_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    // Converter lanes: one bit per cycle of every magnitude
    always_ff @(posedge clk)
    begin
        if (conv_load)
        begin
            for (int i = 0; i < aafe_pkg::NLANE; i++)
            begin
                mag_reg[i] <= mag_load[i];
                bcd_reg[i] <= '0;
            end
            neg_reg <= {s1_pitch_reg[10], s1_roll_reg[14], s1_alt_reg[17],
                        s1_lat_reg[7], s1_vert_reg[7]};
        end
        else if (state_reg == aafe_pkg::CONV_RUN)
        begin
            for (int i = 0; i < aafe_pkg::NLANE; i++)
            begin
                mag_reg[i] <= {mag_reg[i][aafe_pkg::MAG_W-2:0], 1'b0};
                bcd_reg[i] <= aafe_pkg::dd_step(bcd_reg[i], mag_reg[i][aafe_pkg::MAG_W-1]);
            end
        end
    end

    // Finished frame toward the queue
    assign q_valid = (state_reg == aafe_pkg::CONV_DONE);

    always_comb
    begin
        q_data.pitch_neg = neg_reg[4];
        q_data.roll_neg  = neg_reg[3];
        q_data.alt_neg   = neg_reg[2];
        q_data.lat_neg   = neg_reg[1];
        q_data.vert_neg  = neg_reg[0];
        q_data.pitch_bcd = bcd_reg[aafe_pkg::LANE_PITCH][11:0];
        q_data.roll_bcd  = bcd_reg[aafe_pkg::LANE_ROLL][15:0];
        q_data.ias_bcd   = bcd_reg[aafe_pkg::LANE_IAS][15:0];
        q_data.alt_bcd   = bcd_reg[aafe_pkg::LANE_ALT];
        q_data.lat_bcd   = bcd_reg[aafe_pkg::LANE_LAT][7:0];
        q_data.vert_bcd  = bcd_reg[aafe_pkg::LANE_VERT][7:0];
        q_data.lift_bcd  = bcd_reg[aafe_pkg::LANE_LIFT][7:0];
    end

endmodule

@@ design/aafe_fifo.sv @@
// Short register queue of decoded frames between front and back.
`timescale 1ns / 1ps

module aafe_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  aafe_pkg::job_t wr_data,
    output logic           rd_valid,
    input  logic           rd_pop,
    output aafe_pkg::job_t rd_data
);

    aafe_pkg::job_t              mem_reg [aafe_pkg::QDEPTH];
    logic [aafe_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [aafe_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [aafe_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                        push, pop;

    assign wr_ready = (count_reg < aafe_pkg::QCNT_W'(aafe_pkg::QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;
    assign rd_data  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == aafe_pkg::QPTR_W'(aafe_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == aafe_pkg::QPTR_W'(aafe_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ design/aafe_back.sv @@
// Back end: walks the 59 frame positions, sums the payload and drives the output word.
`timescale 1ns / 1ps

module aafe_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_pop,
    input  aafe_pkg::job_t job,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast
);

    aafe_pkg::job_t job_reg;
    logic           active_reg, active_next;
    logic [5:0]     pos_reg, pos_next;
    logic [7:0]     sum_reg, sum_next;
    logic           out_valid_reg, out_valid_next;
    logic [7:0]     out_byte_reg;
    logic           out_last_reg;
    logic           gen, last_pos, load;
    logic [7:0]     cur_byte;

    assign gen      = active_reg && (!out_valid_reg || m_tready);
    assign last_pos = (pos_reg == aafe_pkg::POS_LF);
    assign load     = job_valid && (!active_reg || (gen && last_pos));
    assign job_pop  = load;
    assign cur_byte = aafe_pkg::char_at(pos_reg, job_reg, sum_reg);

    // Position, checksum and output register control
    always_comb
    begin
        active_next    = active_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;

        if (load)
        begin
            active_next = 1'b1;
            pos_next    = '0;
        end
        else if (gen)
        begin
            if (last_pos)
            begin
                active_next = 1'b0;
                pos_next    = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end

        if (gen)
        begin
            if (pos_reg == aafe_pkg::POS_SOF)
            begin
                sum_next = cur_byte;
            end
            else if (pos_reg < aafe_pkg::POS_SUM_HI)
            begin
                sum_next = sum_reg + cur_byte;
            end
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= job;
        end
        if (gen)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= last_pos;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the ASCII attitude frame encoder: directed and random sample words.
`timescale 1ns / 1ps

module tb_top;
    import aafe_pkg::*;

    localparam int FRAME_CHARS   = 59;
    localparam int PAYLOAD_CHARS = 55;
    localparam int SETTLE_CYCLES = 30;
    localparam int IDLE_LIMIT    = 3000;
    localparam int MAX_REPORTS   = 10;
    localparam logic [7:0] CH_HEX_A = 8'h41;

    // One sample set as it travels in s_tdata
    typedef struct packed {
        logic [6:0]         lift;
        logic signed [15:0] vert;
        logic signed [15:0] lat;
        logic signed [17:0] alt;
        logic signed [15:0] ias;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
    } sample_t;

    // One expected output character
    typedef struct {
        logic [7:0] ch;
        logic       last;
    } frame_char_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [7:0]            cfg_wdata = 8'd0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tlast;

    frame_char_t char_q[$];
    logic [7:0]  mute_knots = 8'd0;
    logic [7:0]  frame_buf[FRAME_CHARS];
    int          frame_fill;
    int          error_count = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          stall_left = 0;
    bit          gaps_on = 1'b0;
    bit          stalls_on = 1'b0;

    ascii_attitude_frame_encoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Frame builder
    function automatic int clamp(input int v, input int lo, input int hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function void put_char(input logic [7:0] c);
        frame_buf[frame_fill] = c;
        frame_fill++;
    endfunction

    // Zero-padded decimal, most significant digit first
    function void put_dec(input int mag, input int ndig);
        int div;
        for (int i = ndig - 1; i >= 0; i--)
        begin
            div = 1;
            for (int k = 0; k < i; k++)
            begin
                div = div * 10;
            end
            put_char(CH_ZERO + 8'((mag / div) % 10));
        end
    endfunction

    function void put_signed_dec(input int v, input int ndig);
        put_char((v < 0) ? CH_MINUS : CH_PLUS);
        put_dec((v < 0) ? -v : v, ndig);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? CH_ZERO + {4'h0, n} : CH_HEX_A + {4'h0, n} - 8'd10;
    endfunction

    // Works out the 59 characters of one frame and queues them
    function void encode_frame(input sample_t s);
        int         airspeed;
        int         lift;
        logic [7:0] sum;
        frame_char_t fc;
        airspeed = int'(s.ias);
        lift = int'(s.lift);
        if (airspeed >= 10 * int'(mute_knots))
        begin
            airspeed = clamp(airspeed, 0, 9999);
            lift = clamp(lift, 0, 99);
        end
        else
        begin
            airspeed = 0;
            lift = 0;
        end
        frame_fill = 0;
        put_char(CH_EQ);
        put_char(CH_ONE);
        put_char(CH_ONE);
        for (int i = 0; i < 8; i++)
        begin
            put_char(CH_ZERO);
        end
        put_signed_dec(clamp(int'(s.pitch), -999, 999), 3);
        put_signed_dec(clamp(int'(s.roll), -9999, 9999), 4);
        for (int i = 0; i < 3; i++)
        begin
            put_char(CH_FILL);
        end
        put_dec(airspeed, 4);
        put_signed_dec(clamp(int'(s.alt), -99999, 99999), 5);
        for (int i = 0; i < 4; i++)
        begin
            put_char(CH_FILL);
        end
        put_signed_dec(clamp(int'(s.lat), -99, 99), 2);
        put_signed_dec(clamp(int'(s.vert), -99, 99), 2);
        put_dec(lift, 2);
        for (int i = 0; i < 10; i++)
        begin
            put_char(CH_FILL);
        end
        sum = 8'd0;
        for (int i = 0; i < PAYLOAD_CHARS; i++)
        begin
            sum = sum + frame_buf[i];
        end
        put_char(hex_char(sum[7:4]));
        put_char(hex_char(sum[3:0]));
        put_char(CH_CR);
        put_char(CH_LF);
        for (int i = 0; i < FRAME_CHARS; i++)
        begin
            fc.ch = frame_buf[i];
            fc.last = (i == FRAME_CHARS - 1);
            char_q.push_back(fc);
        end
    endfunction

    // Stimulus helpers
    function automatic sample_t mk(input int p, input int r, input int a, input int h,
                                   input int l, input int v, input int f);
        sample_t s;
        s.pitch = 16'(p);
        s.roll = 16'(r);
        s.ias = 16'(a);
        s.alt = 18'(h);
        s.lat = 16'(l);
        s.vert = 16'(v);
        s.lift = 7'(f);
        return s;
    endfunction

    // Mostly in range, some at and just past the limits, some full-width noise
    function automatic int pick(input int w, input int lo, input int hi);
        int v;
        case ($urandom_range(9))
            0, 1:
            begin
                v = int'($urandom);
                v = (v <<< (32 - w)) >>> (32 - w);
            end
            2: v = lo + int'($urandom_range(2));
            3: v = hi - int'($urandom_range(2));
            4: v = ($urandom_range(1) == 0) ? lo - 1 : hi + 1;
            default: v = lo + int'($urandom_range(hi - lo));
        endcase
        return v;
    endfunction

    function automatic sample_t rand_sample();
        sample_t s;
        int      a;
        if ($urandom_range(3) == 0)
        begin
            a = 10 * int'(mute_knots) + int'($urandom_range(6)) - 3;
        end
        else
        begin
            a = pick(16, 0, 9999);
        end
        s = mk(pick(16, -999, 999), pick(16, -9999, 9999), a, pick(18, -99999, 99999),
               pick(16, -99, 99), pick(16, -99, 99),
               ($urandom_range(4) == 0) ? int'($urandom_range(127)) : int'($urandom_range(99)));
        return s;
    endfunction

    // Sends one sample word; called and returns just after a falling edge
    task automatic send_sample(input sample_t s);
        s_tvalid <= 1'b1;
        s_tdata <= IN_TDATA_W'(s);
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        encode_frame(s);
        @(negedge clk);
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(6, 1)) @(negedge clk);
                burst_left = $urandom_range(8, 1);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    // Waits until every queued character has come out, then lets the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (char_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_mute(input logic [7:0] knots);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= knots;
        @(negedge clk);
        cfg_we <= 1'b0;
        mute_knots = knots;
    endtask

    // Receiver stalls in short random runs while enabled
    always @(negedge clk)
    begin
        if (!stalls_on)
        begin
            m_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(3) == 0)
        begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(3);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Output checker: each accepted word against the oldest expected character
    always @(posedge clk)
    begin
        frame_char_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (char_q.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                begin
                    $display("ERROR: unexpected word data=%h last=%b at %0t",
                             m_tdata, m_tlast, $realtime);
                end
            end
            else
            begin
                want = char_q.pop_front();
                if (m_tdata !== want.ch || m_tlast !== want.last)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("ERROR: word mismatch exp data=%h last=%b got data=%h last=%b at %0t",
                                 want.ch, want.last, m_tdata, m_tlast, $realtime);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Limits, saturation, negative airspeed and lift above 99 at the reset threshold
    task automatic test_field_limits();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        send_sample(mk(0, 0, 0, 0, 0, 0, 0));
        send_sample(mk(999, 9999, 9999, 99999, 99, 99, 99));
        send_sample(mk(-999, -9999, 0, -99999, -99, -99, 0));
        send_sample(mk(1000, 10000, 10000, 100000, 100, 100, 100));
        send_sample(mk(-1000, -10000, -1, -100000, -100, -100, 127));
        send_sample(mk(32767, 32767, 32767, 131071, 32767, 32767, 127));
        send_sample(mk(-32768, -32768, -32768, -131072, -32768, -32768, 0));
        send_sample(mk(1, -1, 1, -1, 1, -1, 1));
        send_sample(mk(-5, 5, 1234, -12345, -7, 42, 50));
        send_sample(mk(123, -4567, 805, 35000, -1, 0, 98));
    endtask

    // Airspeed exactly at and just under the mute threshold
    task automatic test_mute_threshold();
        set_mute(8'd255);
        stalls_on = 1'b1;
        send_sample(mk(10, 20, 2549, 500, 3, 4, 80));
        send_sample(mk(10, 20, 2550, 500, 3, 4, 127));
        send_sample(mk(-10, -20, 32767, -500, -3, -4, 60));
        send_sample(mk(-10, -20, -32768, -500, -3, -4, 60));
        set_mute(8'd1);
        send_sample(mk(0, 0, 9, 0, 0, 0, 50));
        send_sample(mk(0, 0, 10, 0, 0, 0, 50));
    endtask

    task automatic test_random(input int count, input logic [7:0] knots,
                               input bit gaps, input bit stalls);
        set_mute(knots);
        gaps_on = gaps;
        stalls_on = stalls;
        burst_left = 0;
        for (int i = 0; i < count; i++)
        begin
            send_sample(rand_sample());
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_field_limits();
        test_mute_threshold();
        test_random(60, 8'd0, 1'b0, 1'b0);
        test_random(100, 8'($urandom_range(255)), 1'b1, 1'b1);
        test_random(50, 8'd255, 1'b1, 1'b0);
        test_random(100, 8'($urandom_range(30, 1)), 1'b0, 1'b1);
        test_random(45, 8'd0, 1'b1, 1'b1);
        drain();
        if (char_q.size() != 0)
        begin
            error_count++;
        end
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/aafe_pkg.sv
design/aafe_front.sv
design/aafe_fifo.sv
design/aafe_back.sv
design/ascii_attitude_frame_encoder_top.sv
sim/tb_top.sv
